// File: rtl/b64_pkg.sv
`default_nettype none

package b64_pkg;

  // Pad character and the special character values of the alphabet
  localparam logic [7:0] PAD_CHAR    = 8'h3d;
  localparam logic [7:0] PLUS_CHAR   = 8'h2b;
  localparam logic [7:0] SLASH_CHAR  = 8'h2f;
  localparam logic [7:0] LOWER_SHIFT = 8'd71;
  localparam logic [7:0] DIGIT_SHIFT = 8'd4;
  localparam logic [7:0] PLUS_VALUE  = 8'd62;
  localparam logic [7:0] SLASH_VALUE = 8'd63;
  localparam logic [7:0] BAD_VALUE   = 8'd255;

  // Direction register codes
  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } dir_t;

  // Results of one transaction, oldest in slot 0
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            has_data;
  } bundle_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      enc_char = w + 8'h41;
    end else if (v < 6'd52) begin
      enc_char = w + 8'h47;
    end else if (v < 6'd62) begin
      enc_char = w - 8'd4;
    end else if (v == 6'd62) begin
      enc_char = PLUS_CHAR;
    end else begin
      enc_char = SLASH_CHAR;
    end
  endfunction

  // Character to value; anything outside the alphabet gives 255
  function automatic logic [7:0] dec_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a) begin
      dec_value = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      dec_value = c - LOWER_SHIFT;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      dec_value = c + DIGIT_SHIFT;
    end else if (c == PLUS_CHAR) begin
      dec_value = PLUS_VALUE;
    end else if (c == SLASH_CHAR) begin
      dec_value = SLASH_VALUE;
    end else begin
      dec_value = BAD_VALUE;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64_group.sv
`default_nettype none

module b64_group (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_write,
  input  wire logic           cfg_data,
  input  wire logic           accept,
  input  wire logic [7:0]     in_symbol,
  input  wire logic           end_of_message,
  output b64_pkg::bundle_t    bundle
);
  import b64_pkg::*;

  dir_t            direction;
  logic [3:0][7:0] group_store;
  logic [1:0]      group_count;
  logic            pad_seen;

  logic [2:0][7:0] enc_src;
  logic [3:0][5:0] sextet;
  logic            enc_full;
  logic [2:0]      count_plus;

  logic [3:0][7:0] dec_src;
  logic [3:0][7:0] dec_val;
  logic            dec_write;
  logic            dec_full;
  logic [1:0]      dec_count_after;

  // Encode: group bytes with the new byte merged in, later slots zero filled
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (2'(j) == group_count) begin
        enc_src[j] = in_symbol;
      end else if (2'(j) > group_count) begin
        enc_src[j] = 8'h00;
      end else begin
        enc_src[j] = group_store[j];
      end
    end
    sextet[0]  = enc_src[0][7:2];
    sextet[1]  = {enc_src[0][1:0], enc_src[1][7:4]};
    sextet[2]  = {enc_src[1][3:0], enc_src[2][7:6]};
    sextet[3]  = enc_src[2][5:0];
    enc_full   = group_count >= 2'd2;
    count_plus = {1'b0, group_count} + 3'd1;
  end

  // Decode: characters with the new one merged in, then three bytes
  always_comb begin
    dec_write = !pad_seen && (in_symbol != PAD_CHAR);
    for (int j = 0; j < 4; j++) begin
      dec_src[j] = (dec_write && 2'(j) == group_count) ? in_symbol : group_store[j];
      dec_val[j] = dec_value(dec_src[j]);
    end
    dec_full        = dec_write && (group_count == 2'd3);
    dec_count_after = dec_write ? group_count + 2'd1 : group_count;
  end

  // Result bundle for the transaction being accepted
  always_comb begin
    bundle = '0;
    if (direction == DIR_ENCODE) begin
      for (int j = 0; j < 4; j++) begin
        if (!enc_full && count_plus < 3'(j)) begin
          bundle.bytes[j] = PAD_CHAR;
        end else begin
          bundle.bytes[j] = enc_char(sextet[j]);
        end
      end
      bundle.last_idx = 2'd3;
      bundle.has_data = enc_full || end_of_message;
    end else begin
      bundle.bytes[0] = (dec_val[0] << 2) + {6'h00, dec_val[1][5:4]};
      bundle.bytes[1] = {dec_val[1][3:0], 4'h0} + {4'h0, dec_val[2][5:2]};
      bundle.bytes[2] = {dec_val[2][1:0], 6'h00} + dec_val[3];
      if (dec_full) begin
        bundle.last_idx = 2'd2;
        bundle.has_data = 1'b1;
      end else if (end_of_message && dec_count_after >= 2'd2) begin
        bundle.last_idx = dec_count_after - 2'd2;
        bundle.has_data = 1'b1;
      end
    end
  end

  // Direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (cfg_write) begin
      direction <= dir_t'(cfg_data);
    end
  end

  // Group state
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= 2'd0;
      pad_seen    <= 1'b0;
    end else if (accept) begin
      if (direction == DIR_ENCODE) begin
        group_count <= (enc_full || end_of_message) ? 2'd0 : group_count + 2'd1;
        pad_seen    <= end_of_message ? 1'b0 : pad_seen;
      end else begin
        group_count <= end_of_message ? 2'd0 : dec_count_after;
        pad_seen    <= end_of_message ? 1'b0 : (pad_seen || (in_symbol == PAD_CHAR));
      end
    end
  end

  // Symbol store: payload only
  always_ff @(posedge clk) begin
    if (accept && (direction == DIR_ENCODE || dec_write)) begin
      group_store[group_count] <= in_symbol;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64_serialiser.sv
`default_nettype none

module b64_serialiser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  b64_pkg::bundle_t    bundle,
  output logic                free,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_symbol,
  output logic                last_of_run
);
  import b64_pkg::*;

  logic            busy;
  logic [3:0][7:0] bytes;
  logic [1:0]      left;
  logic            take;

  // Output taken this cycle; free when empty or the last result leaves now
  assign take        = busy && !out_stall;
  assign free        = !busy || (take && left == 2'd0);
  assign out_valid   = busy;
  assign out_symbol  = bytes[0];
  assign last_of_run = (left == 2'd0);

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= bundle.has_data;
    end else if (take && left == 2'd0) begin
      busy <= 1'b0;
    end
  end

  // Result shift register
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= bundle.bytes;
      left  <= bundle.last_idx;
    end else if (take) begin
      bytes <= {8'h00, bytes[3:1]};
      left  <= left - 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/base64_codec_stream.sv
// Streaming Base64 codec, standard alphabet with '=' padding.
// Input channel: in_symbol and end_of_message, with in_valid / in_stall.
// Output channel: out_symbol and last_of_run, with out_valid / out_stall.
// A transaction moves when valid is high and stall is low.
// cfg_write / cfg_data set the direction: 0 encodes bytes, 1 decodes characters.
// Write it only while the block is idle.
// Each input transaction yields 0 to 4 results; the last carries last_of_run.
// Results appear from the cycle after acceptance and leave an output shift register
// one per cycle while the receiver does not stall.
// Every item waits while results are being shifted out; the next one is taken in
// the cycle the final result leaves.
// Items that yield no results are taken whenever the output register is free.
// When the receiver stalls, the current result holds and in_stall stays high
// while the output register holds results.
// Reset (rst, synchronous) empties the output and clears group state and the
// direction register (encode).
`default_nettype none

module base64_codec_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_symbol,
  input  wire logic       end_of_message,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_symbol,
  output logic            last_of_run
);
  import b64_pkg::*;

  bundle_t bundle;
  logic    free;
  logic    accept;

  assign in_stall = !free;
  assign accept   = in_valid && free;

  // Group assembly and result computation
  b64_group u_group (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .in_symbol      (in_symbol),
    .end_of_message (end_of_message),
    .bundle         (bundle)
  );

  // Result register and serialiser
  b64_serialiser u_serialiser (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .bundle      (bundle),
    .free        (free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_symbol  (out_symbol),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
